// ===== src/frc_pkg.sv =====
// shared constants and beat types of the fifo replacement cache
`timescale 1ns / 1ps
package frc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int CAP_W      = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_STORE  = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic                         mode;
		logic [KEY_BITS-1:0]          key;
		logic signed [VALUE_BITS-1:0] value;
	} in_t;

	typedef struct packed {
		logic                         found;
		logic signed [VALUE_BITS-1:0] read_value;
		logic                         evicted;
		logic [KEY_BITS-1:0]          evicted_key;
	} out_t;

endpackage

// ===== src/frc_mem.sv =====
// key and value storage: one write port, one registered read port
`timescale 1ns / 1ps
module frc_mem (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  frc_pkg::idx_t                          wr_addr,
	input  logic [frc_pkg::KEY_BITS-1:0]           wr_key,
	input  logic signed [frc_pkg::VALUE_BITS-1:0]  wr_value,
	input  frc_pkg::idx_t                          rd_addr,
	output logic [frc_pkg::KEY_BITS-1:0]           rd_key,
	output logic signed [frc_pkg::VALUE_BITS-1:0]  rd_value
);

	logic [frc_pkg::KEY_BITS-1:0]          key_mem   [frc_pkg::ENTRIES];
	logic signed [frc_pkg::VALUE_BITS-1:0] value_mem [frc_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= wr_key;
			value_mem[wr_addr] <= wr_value;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_key   <= key_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
	end

endmodule

// ===== src/fifo_replacement_cache.sv =====
// top level: fully associative key/value cache with fifo replacement
`timescale 1ns / 1ps
// usage
//   command channel: an item (mode, key, value) is taken on a rising edge with
//   start high and busy low. mode lookup reports found and the stored value;
//   mode store overwrites a present key in place (age kept) or writes a new
//   key as the newest entry, first evicting the oldest one once the cache
//   holds capacity entries
//   result channel: one result beat per item, on result for exactly one
//   cycle with done high; there is no back pressure, the receiver must take it
//   configuration: cfg_we with cfg_wdata writes capacity (0 acts as 1, values
//   above 16 act as 16); write it only while busy is low
// timing
//   one key comparator walks the 16 slots through the registered read port
//   of the storage: a scan step per slot, a drain step for the last compare, a
//   decide step that reads the hit or oldest slot and a finish step; done rises
//   at the edge that ends the finish step and busy falls with it; the next item
//   can be taken at the edge that ends the done cycle
// reset
//   arst_n clears all valid bits, the fifo pointer, the entry count and sets
//   capacity to 16; key and value storage is not cleared
module fifo_replacement_cache (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  frc_pkg::in_t                item,
	input  logic                        cfg_we,
	input  logic [frc_pkg::CAP_W-1:0]   cfg_wdata,
	output logic                        done,
	output frc_pkg::out_t               result
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]                    state_q;
	frc_pkg::in_t                  item_q;
	logic [frc_pkg::CAP_W-1:0]     cap_q;
	logic [frc_pkg::ENTRIES-1:0]   valid_q;
	frc_pkg::idx_t                 oldest_q;
	logic [frc_pkg::CNT_W-1:0]     count_q;
	frc_pkg::idx_t                 scan_idx_q;
	logic                          cmp_vld_s1;
	frc_pkg::idx_t                 cmp_idx_s1;
	logic                          hit_q;
	frc_pkg::idx_t                 hit_idx_q;
	logic                          done_q;
	frc_pkg::out_t                 result_q;

	// storage port signals
	logic                                   wr_en;
	frc_pkg::idx_t                          wr_addr;
	frc_pkg::idx_t                          rd_addr;
	logic [frc_pkg::KEY_BITS-1:0]           rd_key;
	logic signed [frc_pkg::VALUE_BITS-1:0]  rd_value;

	logic                          accept;
	logic                          match;
	logic [frc_pkg::CNT_W-1:0]     eff_cap;
	logic                          full;
	logic                          store_miss;
	logic                          do_evict;
	frc_pkg::idx_t                 new_pos;
	logic [frc_pkg::ENTRIES-1:0]   valid_upd;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// capacity 0 behaves as 1, anything above the slot count saturates
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = frc_pkg::CNT_W'(1);
		end else if (cap_q > frc_pkg::CAP_W'(frc_pkg::ENTRIES)) begin
			eff_cap = frc_pkg::CNT_W'(frc_pkg::ENTRIES);
		end else begin
			eff_cap = frc_pkg::CNT_W'(cap_q);
		end
	end

	assign full       = (count_q >= eff_cap) && (count_q != '0);
	assign store_miss = (item_q.mode == frc_pkg::MODE_STORE) && !hit_q;
	assign do_evict   = store_miss && full;
	// the new slot sits count places after oldest; an eviction moves oldest up, count stays
	assign new_pos    = oldest_q + count_q[frc_pkg::IDX_W-1:0];

	// valid bits after a store miss
	always_comb begin
		valid_upd = valid_q;
		if (do_evict) begin
			valid_upd[oldest_q] = 1'b0;
		end
		// set after the clear: a full ring reuses the evicted slot
		valid_upd[new_pos] = 1'b1;
	end

	// the shared comparator, one slot a cycle, in the cycle after its read address
	assign match = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rd_key == item_q.key);

	// read address: scan slot, then hit slot or oldest slot for the finish step
	always_comb begin
		if (state_q == ST_DECIDE) begin
			rd_addr = store_miss ? oldest_q : hit_idx_q;
		end else begin
			rd_addr = scan_idx_q;
		end
	end

	assign wr_en   = (state_q == ST_FINISH) && (item_q.mode == frc_pkg::MODE_STORE);
	assign wr_addr = hit_q ? hit_idx_q : new_pos;

	frc_mem u_mem (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_key   (item_q.key),
		.wr_value (item_q.value),
		.rd_addr  (rd_addr),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	// item beat register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			result_q.found       <= hit_q;
			result_q.read_value  <= ((item_q.mode == frc_pkg::MODE_LOOKUP) && hit_q)
			                        ? rd_value : '0;
			result_q.evicted     <= do_evict;
			result_q.evicted_key <= do_evict ? rd_key : '0;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= frc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			done_q     <= 1'b0;
			valid_q    <= '0;
			oldest_q   <= '0;
			count_q    <= '0;
		end else begin
			done_q     <= 1'b0;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			cmp_idx_s1 <= scan_idx_q;
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= cmp_idx_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == frc_pkg::IDX_W'(frc_pkg::ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (store_miss) begin
						valid_q <= valid_upd;
						if (do_evict) begin
							oldest_q <= oldest_q + 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// valid bits and the entry count must always agree
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
	else $error("valid bits disagree with entry count");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= frc_pkg::CNT_W'(frc_pkg::ENTRIES))
	else $error("entry count beyond slot count");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_FINISH) && !busy)
	else $error("result beat outside the finish step");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.evicted && result_q.found))
	else $error("eviction reported on a hit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.evicted) |=> $stable(count_q))
	else $error("entry count moved after an eviction beat");

endmodule
